// ===== rtl/enhanced_clock_page_replacer_macros.svh =====
// Assertion helpers for the replacer RTL.
`ifndef ENHANCED_CLOCK_PAGE_REPLACER_MACROS_SVH
`define ENHANCED_CLOCK_PAGE_REPLACER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecpr: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ECPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecpr: assertion failed");

`endif

// ===== rtl/ecpr_pkg.sv =====
package ecpr_pkg;

    localparam int SLOTS     = 64;
    localparam int PAGE_BITS = 20;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] OCC_FULL = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_ACCESS = 2'd1,
        KIND_VICTIM = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_ROTATE,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_FLAGS,
        CELL_TOUCH,
        CELL_MARK,
        CELL_ROTATE
    } t_cell_op;

    // Which class of entry becomes the victim.
    typedef enum logic [1:0] {
        VSEL_A0D0,
        VSEL_A0,
        VSEL_D0,
        VSEL_HAND
    } t_vsel;

    typedef struct packed {
        t_cell_op             op;
        t_vsel                vsel;
        logic [PAGE_BITS-1:0] page;
        logic                 wr;
        logic [CNT_W-1:0]     occ;
    } t_cmd;

    // Prefix flags carried from position zero toward the tail.
    typedef struct packed {
        logic hit;
        logic a0d0;
        logic a0;
        logic d0;
    } t_link;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 acc;
        logic                 dirty;
        logic                 tag;
    } t_entry;

endpackage

// ===== rtl/ecpr_cell.sv =====
module ecpr_cell (
    input  logic                         i_clk,
    input  ecpr_pkg::t_cmd               i_cmd,
    input  logic [ecpr_pkg::IDX_W-1:0]   i_index,
    input  ecpr_pkg::t_link              i_link,
    output ecpr_pkg::t_link              o_link,
    input  ecpr_pkg::t_entry             i_right,
    input  ecpr_pkg::t_entry             i_wrap,
    output ecpr_pkg::t_entry             o_entry
);

    ecpr_pkg::t_entry r_entry, n_entry;
    logic r_f_hit, n_f_hit;
    logic r_f_a0d0, n_f_a0d0;
    logic r_f_a0, n_f_a0;
    logic r_f_d0, n_f_d0;
    logic r_f_pre, n_f_pre;

    logic [ecpr_pkg::CNT_W-1:0] w_pos;
    logic [ecpr_pkg::CNT_W-1:0] w_pos_next;
    logic w_valid, w_is_tail, w_is_ins;
    logic w_hit, w_a0, w_a0d0, w_d0;

    assign w_pos      = ecpr_pkg::CNT_W'(i_index);
    assign w_pos_next = w_pos + ecpr_pkg::CNT_W'(1);
    assign w_valid    = w_pos < i_cmd.occ;
    assign w_is_tail  = w_pos_next == i_cmd.occ;
    assign w_is_ins   = w_pos == i_cmd.occ;

    assign w_hit  = w_valid && (r_entry.page == i_cmd.page);
    assign w_a0   = w_valid && !r_entry.acc;
    assign w_a0d0 = w_a0 && !r_entry.dirty;
    assign w_d0   = w_valid && !r_entry.dirty;

    assign o_link.hit  = i_link.hit  | w_hit;
    assign o_link.a0d0 = i_link.a0d0 | w_a0d0;
    assign o_link.a0   = i_link.a0   | w_a0;
    assign o_link.d0   = i_link.d0   | w_d0;

    assign o_entry = r_entry;

    always_comb begin
        n_entry  = r_entry;
        n_f_hit  = r_f_hit;
        n_f_a0d0 = r_f_a0d0;
        n_f_a0   = r_f_a0;
        n_f_d0   = r_f_d0;
        n_f_pre  = r_f_pre;
        case (i_cmd.op)
            ecpr_pkg::CELL_INSERT: begin
                if (w_is_ins) begin
                    n_entry.page  = i_cmd.page;
                    n_entry.acc   = 1'b0;
                    n_entry.dirty = 1'b0;
                    n_entry.tag   = 1'b0;
                end
            end
            ecpr_pkg::CELL_FLAGS: begin
                // keep only the first position of each class
                n_f_hit  = w_hit  && !i_link.hit;
                n_f_a0d0 = w_a0d0 && !i_link.a0d0;
                n_f_a0   = w_a0   && !i_link.a0;
                n_f_d0   = w_d0   && !i_link.d0;
                n_f_pre  = !(i_link.a0 | w_a0);
            end
            ecpr_pkg::CELL_TOUCH: begin
                if (r_f_hit) begin
                    n_entry.acc = 1'b1;
                    if (i_cmd.wr) begin
                        n_entry.dirty = 1'b1;
                    end
                end
            end
            ecpr_pkg::CELL_MARK: begin
                case (i_cmd.vsel)
                    ecpr_pkg::VSEL_A0D0: begin
                        n_entry.tag = r_f_a0d0;
                    end
                    ecpr_pkg::VSEL_A0: begin
                        n_entry.tag = r_f_a0;
                        if (r_f_pre) begin
                            n_entry.acc = 1'b0;
                        end
                    end
                    ecpr_pkg::VSEL_D0: begin
                        n_entry.tag = r_f_d0;
                        n_entry.acc = 1'b0;
                    end
                    default: begin
                        n_entry.tag = (i_index == '0);
                        n_entry.acc = 1'b0;
                    end
                endcase
            end
            ecpr_pkg::CELL_ROTATE: begin
                // advance toward the hand; the tail takes the old head
                if (w_is_tail) begin
                    n_entry = i_wrap;
                end else if (w_valid) begin
                    n_entry = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_f_hit  <= n_f_hit;
        r_f_a0d0 <= n_f_a0d0;
        r_f_a0   <= n_f_a0;
        r_f_d0   <= n_f_d0;
        r_f_pre  <= n_f_pre;
    end

endmodule

// ===== rtl/enhanced_clock_page_replacer.sv =====
// Steps from accepted word to result word: insert and unused kind go scan, response;
// access goes scan, decide, response; victim select goes scan, decide, then rotates
// the ring one entry per cycle until the victim sits at the hand, then response.
// One word in flight; the next word is taken while a result waits.
// Reset (synchronous, active low) empties the ring; entry contents stay undefined.
module enhanced_clock_page_replacer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_kind,
    input  logic [ecpr_pkg::PAGE_BITS-1:0]  i_page_number,
    input  logic                            i_is_write,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [ecpr_pkg::PAGE_BITS-1:0]  o_victim_page,
    output logic                            o_victim_dirty
);

    `include "enhanced_clock_page_replacer_macros.svh"

    ecpr_pkg::t_state  r_state, n_state;
    logic [ecpr_pkg::CNT_W-1:0] r_occ, n_occ;
    ecpr_pkg::t_kind   r_kind, n_kind;
    logic [ecpr_pkg::PAGE_BITS-1:0] r_page, n_page;
    logic              r_wr, n_wr;
    ecpr_pkg::t_link   r_any, n_any;
    ecpr_pkg::t_status r_status, n_status;
    logic [ecpr_pkg::PAGE_BITS-1:0] r_vpage, n_vpage;
    logic              r_vdirty, n_vdirty;
    logic              r_out_valid, n_out_valid;
    ecpr_pkg::t_status r_out_status, n_out_status;
    logic [ecpr_pkg::PAGE_BITS-1:0] r_out_page, n_out_page;
    logic              r_out_dirty, n_out_dirty;

    ecpr_pkg::t_cmd    w_cmd;
    ecpr_pkg::t_link   w_link  [ecpr_pkg::SLOTS+1];
    ecpr_pkg::t_entry  w_entry [ecpr_pkg::SLOTS];
    logic [ecpr_pkg::SLOTS-1:0] w_tags;

    assign w_link[0] = '0;

    for (genvar g = 0; g < ecpr_pkg::SLOTS; g++) begin : g_cell
        ecpr_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (ecpr_pkg::IDX_W'(g)),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .i_right (w_entry[(g + 1) % ecpr_pkg::SLOTS]),
            .i_wrap  (w_entry[0]),
            .o_entry (w_entry[g])
        );
        assign w_tags[g] = w_entry[g].tag;
    end

    assign o_in_stall     = (r_state != ecpr_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_victim_page  = r_out_page;
    assign o_victim_dirty = r_out_dirty;

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_kind       = r_kind;
        n_page       = r_page;
        n_wr         = r_wr;
        n_any        = r_any;
        n_status     = r_status;
        n_vpage      = r_vpage;
        n_vdirty     = r_vdirty;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_dirty  = r_out_dirty;

        w_cmd.op   = ecpr_pkg::CELL_HOLD;
        w_cmd.vsel = ecpr_pkg::VSEL_HAND;
        w_cmd.page = r_page;
        w_cmd.wr   = r_wr;
        w_cmd.occ  = r_occ;

        unique case (r_state)
            ecpr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = ecpr_pkg::t_kind'(i_kind);
                    n_page  = i_page_number;
                    n_wr    = i_is_write;
                    n_state = ecpr_pkg::S_SCAN;
                end
            end
            ecpr_pkg::S_SCAN: begin
                n_status = ecpr_pkg::STATUS_DONE;
                n_vpage  = '0;
                n_vdirty = 1'b0;
                n_state  = ecpr_pkg::S_RESP;
                unique case (r_kind)
                    ecpr_pkg::KIND_INSERT: begin
                        if (r_occ == ecpr_pkg::OCC_FULL) begin
                            n_status = ecpr_pkg::STATUS_FULL;
                        end else begin
                            w_cmd.op = ecpr_pkg::CELL_INSERT;
                            n_occ    = r_occ + ecpr_pkg::CNT_W'(1);
                        end
                    end
                    ecpr_pkg::KIND_ACCESS: begin
                        w_cmd.op = ecpr_pkg::CELL_FLAGS;
                        n_any    = w_link[ecpr_pkg::SLOTS];
                        n_state  = ecpr_pkg::S_DECIDE;
                    end
                    ecpr_pkg::KIND_VICTIM: begin
                        if (r_occ == '0) begin
                            n_status = ecpr_pkg::STATUS_EMPTY;
                        end else begin
                            w_cmd.op = ecpr_pkg::CELL_FLAGS;
                            n_any    = w_link[ecpr_pkg::SLOTS];
                            n_state  = ecpr_pkg::S_DECIDE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ecpr_pkg::S_DECIDE: begin
                if (r_kind == ecpr_pkg::KIND_ACCESS) begin
                    if (r_any.hit) begin
                        w_cmd.op = ecpr_pkg::CELL_TOUCH;
                    end else begin
                        n_status = ecpr_pkg::STATUS_MISS;
                    end
                    n_state = ecpr_pkg::S_RESP;
                end else begin
                    // clean unreferenced first, then unreferenced, then clean, then the entry at the hand
                    w_cmd.op = ecpr_pkg::CELL_MARK;
                    if (r_any.a0d0) begin
                        w_cmd.vsel = ecpr_pkg::VSEL_A0D0;
                    end else if (r_any.a0) begin
                        w_cmd.vsel = ecpr_pkg::VSEL_A0;
                    end else if (r_any.d0) begin
                        w_cmd.vsel = ecpr_pkg::VSEL_D0;
                    end else begin
                        w_cmd.vsel = ecpr_pkg::VSEL_HAND;
                    end
                    n_state = ecpr_pkg::S_ROTATE;
                end
            end
            ecpr_pkg::S_ROTATE: begin
                w_cmd.op = ecpr_pkg::CELL_ROTATE;
                // victim at the hand: this shift parks it at the tail, then drop it
                if (w_entry[0].tag) begin
                    n_vpage  = w_entry[0].page;
                    n_vdirty = w_entry[0].dirty;
                    n_occ    = r_occ - ecpr_pkg::CNT_W'(1);
                    n_state  = ecpr_pkg::S_RESP;
                end
            end
            ecpr_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_page   = r_vpage;
                    n_out_dirty  = r_vdirty;
                    n_state      = ecpr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ecpr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecpr_pkg::S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_page       <= n_page;
        r_wr         <= n_wr;
        r_any        <= n_any;
        r_status     <= n_status;
        r_vpage      <= n_vpage;
        r_vdirty     <= n_vdirty;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_dirty  <= n_out_dirty;
    end

    `ECPR_ASSERT_IMPL(a_occ_range, i_clk, i_rst_n, 1'b1, r_occ <= ecpr_pkg::OCC_FULL)
    `ECPR_ASSERT_IMPL(a_one_victim, i_clk, i_rst_n, r_state == ecpr_pkg::S_ROTATE, $onehot(w_tags))
    `ECPR_ASSERT_NEXT(a_drop_one, i_clk, i_rst_n,
        (r_state == ecpr_pkg::S_ROTATE) && w_entry[0].tag,
        (r_occ == $past(r_occ) - ecpr_pkg::CNT_W'(1)) && (r_state == ecpr_pkg::S_RESP))

endmodule
